>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low reset that disables it.
`define NWT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("nwt assertion failed");

// Implication form built on the macro above.
`define NWT_ASSERT_IMP(label, clk, rst_n, cond, conseq) \
	`NWT_ASSERT(label, clk, rst_n, (cond) |-> (conseq))

`endif

>>> hdl/nwt_pkg.sv
// Types, constants and codes shared by the translation table modules.
package nwt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam int IP_W = 32;
	localparam int PORT_W = 16;
	localparam int VAL_W = 48;
	localparam int KEY_W = IP_W + PORT_W + 2;
	localparam int ENTRY_W = KEY_W + VAL_W;

	// Command kinds passed from the front part to the engine.
	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_INSERT = 2'd2;

	// Operation codes on the request port.
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	// Match kinds reported with a result.
	localparam logic [1:0] MK_NONE = 2'd0;
	localparam logic [1:0] MK_EXACT = 2'd1;
	localparam logic [1:0] MK_ADDR = 2'd2;
	localparam logic [1:0] MK_PORT = 2'd3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Key layout: address wildcard, port wildcard, address, port.
	typedef logic [KEY_W-1:0] key_t;
	typedef logic [VAL_W-1:0] val_t;

	typedef struct packed {
		logic [1:0] kind;
		key_t key_a;
		key_t key_b;
		key_t key_c;
		val_t value;
	} cmd_t;

	typedef struct packed {
		logic hit;
		val_t found_value;
		logic [1:0] match_kind;
		logic table_full;
	} res_t;

endpackage

>>> hdl/nwt_front.sv
// Front part: accepts requests, builds the search keys and classifies them.
module nwt_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic operation,
	input  logic [31:0] ip_address,
	input  logic ip_any,
	input  logic [15:0] port_number,
	input  logic port_any,
	input  logic [47:0] new_value,
	output logic cmd_valid,
	output nwt_pkg::cmd_t cmd,
	input  logic q_full
);
	import nwt_pkg::*;

	logic vld_q;
	cmd_t cmd_q;
	cmd_t cmd_d;
	logic accept;
	logic push;
	key_t ins_key;

	// The stage holds one request until the queue has room for it.
	assign push = vld_q && !q_full;
	assign in_stall = vld_q && q_full;
	assign accept = in_valid && !in_stall;

	// Wildcarded parts of an insert key are stored as zero.
	assign ins_key = {ip_any, port_any, ip_any ? {IP_W{1'b0}} : ip_address,
		port_any ? {PORT_W{1'b0}} : port_number};

	// Classify the request and prepare the three lookup keys.
	always_comb begin
		cmd_d.value = new_value;
		cmd_d.key_a = ins_key;
		cmd_d.key_b = ins_key;
		cmd_d.key_c = ins_key;
		cmd_d.kind = CMD_NONE;
		if (operation == OP_INSERT) begin
			if (!(ip_any && port_any))
				cmd_d.kind = CMD_INSERT;
		end else if (!ip_any && !port_any) begin
			cmd_d.kind = CMD_LOOKUP;
			cmd_d.key_a = {1'b0, 1'b0, ip_address, port_number};
			cmd_d.key_b = {1'b0, 1'b1, ip_address, {PORT_W{1'b0}}};
			cmd_d.key_c = {1'b1, 1'b0, {IP_W{1'b0}}, port_number};
		end
	end

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (accept) begin
			vld_q <= 1'b1;
		end else if (push) begin
			vld_q <= 1'b0;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (accept)
			cmd_q <= cmd_d;
	end

	assign cmd_valid = vld_q;
	assign cmd = cmd_q;

endmodule

>>> hdl/nwt_queue.sv
// Short command queue between the front part and the engine.
module nwt_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  nwt_pkg::cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output nwt_pkg::cmd_t q_cmd
);
	import nwt_pkg::*;

	cmd_t slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_cmd = slots_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && q_valid;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// Slot storage.
	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= push_cmd;
	end

endmodule

>>> hdl/nwt_engine.sv
// Engine: scans the rule memory for each lookup or insert command and holds the result.
module nwt_engine (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  nwt_pkg::cmd_t q_cmd,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output nwt_pkg::res_t res
);
	import nwt_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];

	logic [1:0] state_q;
	cmd_t cmd_q;
	logic [CNT_W-1:0] addr_q;
	logic [CNT_W-1:0] used_q;
	logic rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [ENTRY_W-1:0] rdata_s1;
	logic f1_q, f2_q, f3_q;
	val_t v1_q, v2_q, v3_q;
	logic [IDX_W-1:0] slot_q;
	logic out_valid_q;
	res_t res_q;

	logic issue;
	key_t key_rd;
	val_t val_rd;
	logic m1, m2, m3;
	logic out_free;
	logic finish;
	logic full_now;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	res_t res_d;

	// Entries fill in order and are never removed, so the fill count marks validity.
	assign issue = (state_q == ST_SCAN) && (addr_q < used_q);
	assign key_rd = rdata_s1[ENTRY_W-1 -: KEY_W];
	assign val_rd = rdata_s1[VAL_W-1:0];
	assign m1 = rd_vld_s1 && (key_rd == cmd_q.key_a);
	assign m2 = rd_vld_s1 && (key_rd == cmd_q.key_b);
	assign m3 = rd_vld_s1 && (key_rd == cmd_q.key_c);

	assign pop = (state_q == ST_IDLE) && q_valid;
	assign out_free = !out_valid_q || !out_stall;
	assign finish = (state_q == ST_DONE) && out_free;

	// An insert of a new key is refused when every entry is in use.
	assign full_now = !f1_q && (used_q == CNT_W'(TABLE_ENTRIES));
	assign wr_en = finish && (cmd_q.kind == CMD_INSERT) && !full_now;
	assign wr_addr = f1_q ? slot_q : used_q[IDX_W-1:0];

	// Result selection in lookup priority order.
	always_comb begin
		res_d = '0;
		case (cmd_q.kind)
			CMD_LOOKUP: begin
				if (f1_q) begin
					res_d.hit = 1'b1;
					res_d.found_value = v1_q;
					res_d.match_kind = MK_EXACT;
				end else if (f2_q) begin
					res_d.hit = 1'b1;
					res_d.found_value = v2_q;
					res_d.match_kind = MK_ADDR;
				end else if (f3_q) begin
					res_d.hit = 1'b1;
					res_d.found_value = v3_q;
					res_d.match_kind = MK_PORT;
				end
			end
			CMD_INSERT: begin
				res_d.table_full = full_now;
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	// Rule memory with one write port and a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= {cmd_q.key_a, cmd_q.value};
		if (issue)
			rdata_s1 <= mem[addr_q[IDX_W-1:0]];
	end

	// Sequencer, scan flags, fill count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q <= '0;
			used_q <= '0;
			rd_vld_s1 <= 1'b0;
			f1_q <= 1'b0;
			f2_q <= 1'b0;
			f3_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			// A new result replaces one that is taken in the same cycle.
			if (finish)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						addr_q <= '0;
						f1_q <= 1'b0;
						f2_q <= 1'b0;
						f3_q <= 1'b0;
						state_q <= (q_cmd.kind == CMD_NONE) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue)
						addr_q <= addr_q + 1'b1;
					if (m1)
						f1_q <= 1'b1;
					if (m2)
						f2_q <= 1'b1;
					if (m3)
						f3_q <= 1'b1;
					if (!issue && !rd_vld_s1)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (wr_en && !f1_q)
							used_q <= used_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command, matched values and result payload.
	always_ff @(posedge clk) begin
		if (pop)
			cmd_q <= q_cmd;
		if (issue)
			rd_idx_s1 <= addr_q[IDX_W-1:0];
		if (m1) begin
			v1_q <= val_rd;
			slot_q <= rd_idx_s1;
		end
		if (m2)
			v2_q <= val_rd;
		if (m3)
			v3_q <= val_rd;
		if (finish)
			res_q <= res_d;
	end

	assign out_valid = out_valid_q;
	assign res = res_q;

endmodule

>>> hdl/nat_wildcard_table_lookup.sv
// Top level of the wildcard translation table.
//
//   channel  handshake            payload
//   request  in_valid/in_stall    operation ip_address ip_any port_number port_any new_value
//   result   out_valid/out_stall  hit found_value match_kind table_full
//
// For a lookup or insert the engine scans the rules stored (up to 64), reading the
// rule memory one entry per cycle; wildcard lookups and ignored inserts skip the scan.
// Reset empties the table at once through the fill count; no clearing pass.
// The queue holds up to two requests while the engine is busy or the result stalls;
// when it is full, the front stage holds one more request and raises in_stall.
module nat_wildcard_table_lookup (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic operation,
	input  logic [31:0] ip_address,
	input  logic ip_any,
	input  logic [15:0] port_number,
	input  logic port_any,
	input  logic [47:0] new_value,
	output logic out_valid,
	input  logic out_stall,
	output logic hit,
	output logic [47:0] found_value,
	output logic [1:0] match_kind,
	output logic table_full
);
	import nwt_pkg::*;

	logic f_valid;
	cmd_t f_cmd;
	logic q_full;
	logic q_valid;
	cmd_t q_cmd;
	logic q_pop;
	res_t res;

	// Front part: classification and key building.
	nwt_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.ip_address(ip_address),
		.ip_any(ip_any),
		.port_number(port_number),
		.port_any(port_any),
		.new_value(new_value),
		.cmd_valid(f_valid),
		.cmd(f_cmd),
		.q_full(q_full)
	);

	// Command queue.
	nwt_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(f_valid),
		.push_cmd(f_cmd),
		.full(q_full),
		.pop(q_pop),
		.q_valid(q_valid),
		.q_cmd(q_cmd)
	);

	// Back part: table scan and result register.
	nwt_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_cmd(q_cmd),
		.pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.res(res)
	);

	// Result fields onto the ports.
	assign hit = res.hit;
	assign found_value = res.found_value;
	assign match_kind = res.match_kind;
	assign table_full = res.table_full;

endmodule

>>> hdl/nwt_checker.sv
// Port-level checker for the translation table, bound to the top level.
`include "assert_macros.svh"

module nwt_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic hit,
	input logic [47:0] found_value,
	input logic [1:0] match_kind,
	input logic table_full
);
	import nwt_pkg::*;

	// A stalled result stays and keeps its value.
	`NWT_ASSERT_IMP(a_out_hold, clk, arst_n, out_valid && out_stall, ##1 (out_valid && $stable(found_value) && $stable(match_kind)))

	// A hit always reports a match kind, and a miss reports none.
	`NWT_ASSERT_IMP(a_hit_kind, clk, arst_n, out_valid, hit == (match_kind != MK_NONE))

	// A miss carries a zero value.
	`NWT_ASSERT_IMP(a_miss_zero, clk, arst_n, out_valid && !hit, found_value == '0)

	// A refused insert never reports a hit.
	`NWT_ASSERT_IMP(a_full_no_hit, clk, arst_n, out_valid && table_full, !hit)

endmodule

bind nat_wildcard_table_lookup nwt_checker u_nwt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.hit(hit),
	.found_value(found_value),
	.match_kind(match_kind),
	.table_full(table_full)
);
